// File: design/marker_gradient_area_density_defines.svh
// Assertion macros shared by the area density block.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MARKER_GRADIENT_AREA_DENSITY_DEFINES_SVH
`define MARKER_GRADIENT_AREA_DENSITY_DEFINES_SVH

// Check a property while out of reset.
`define MGAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MGAD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mgad_pkg.sv
// Shared types and constants for the marker gradient area density block.
// No dependencies.
`timescale 1ns / 1ps
package mgad_pkg;

    localparam int INV_W   = 32;
    localparam int MAG_W   = 5;                  // |g| <= 16
    localparam int SQ_W    = 2 * INV_W + 2 * MAG_W - 1; // 73 bits, holds (|g|*inv)^2
    localparam int SUM_W   = SQ_W + 2;
    localparam int RAD_W   = 76;                 // even width for the root recurrence
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int OUT_W   = 40;
    localparam int FRAC_DROP = 4;
    localparam logic [15:0] LEVEL_RESET = 16'd16384;

    // Thresholded neighborhood of one cell.
    typedef struct packed {
        logic w, e, s, n, b, t;
        logic ws, wn, es, en_, wb, wt, eb, et, sb, st, nb, nt;
        logic wsb, esb, wnb, enb, wst, est, wnt, ent;
    } cell_flags_t;

    // Per-axis view: positive and negative side of the face, node and edge sets.
    typedef struct packed {
        logic       face_p;
        logic       face_m;
        logic [3:0] node_p;
        logic [3:0] node_m;
        logic [3:0] edge_p;
        logic [3:0] edge_m;
    } lane_flags_t;

endpackage

// File: design/mgad_flags.sv
// Threshold stage: unpacks samples and compares face and edge sums and node samples to the level.
// Depends on mgad_pkg.
`timescale 1ns / 1ps
module mgad_flags #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [15:0]              level,
    input  logic [15:0]              center_value,
    input  logic [47:0]              face_west_east_south,
    input  logic [47:0]              face_north_bottom_top,
    input  logic [63:0]              edges_xy,
    input  logic [63:0]              edges_xz,
    input  logic [63:0]              edges_yz,
    input  logic [63:0]              nodes_low,
    input  logic [63:0]              nodes_high,
    input  logic [mgad_pkg::INV_W-1:0] inv_dx,
    input  logic [mgad_pkg::INV_W-1:0] inv_dy,
    input  logic [mgad_pkg::INV_W-1:0] inv_dz,
    output mgad_pkg::cell_flags_t    flags,
    output logic [mgad_pkg::INV_W-1:0] inv_x,
    output logic [mgad_pkg::INV_W-1:0] inv_y,
    output logic [mgad_pkg::INV_W-1:0] inv_z
);
    localparam int SB = SAMPLE_BITS;

    function automatic logic [SB-1:0] pick(input logic [63:0] word, input int idx);
        logic [127:0] ext;
        ext = {64'd0, word} >> (idx * SB);
        return ext[SB-1:0];
    endfunction

    logic [SB-1:0] c, lvl;
    logic [SB-1:0] w, e, s, n, b, t;
    logic [SB+1:0] l2, l4;
    mgad_pkg::cell_flags_t flags_next, flags_reg;
    logic [mgad_pkg::INV_W-1:0] inv_x_reg, inv_y_reg, inv_z_reg;

    function automatic logic face_f(input logic [SB-1:0] a, input logic [SB-1:0] cc,
                                    input logic [SB+1:0] lim);
        return ((SB+2)'(a) + (SB+2)'(cc)) >= lim;
    endfunction

    function automatic logic edge_f(input logic [SB-1:0] cc, input logic [SB-1:0] d,
                                    input logic [SB-1:0] a, input logic [SB-1:0] bb,
                                    input logic [SB+1:0] lim);
        return ((SB+2)'(cc) + (SB+2)'(d) + (SB+2)'(a) + (SB+2)'(bb)) >= lim;
    endfunction

    always_comb
    begin
        c   = pick({48'd0, center_value}, 0);
        lvl = pick({48'd0, level}, 0);
        w = pick({16'd0, face_west_east_south}, 0);
        e = pick({16'd0, face_west_east_south}, 1);
        s = pick({16'd0, face_west_east_south}, 2);
        n = pick({16'd0, face_north_bottom_top}, 0);
        b = pick({16'd0, face_north_bottom_top}, 1);
        t = pick({16'd0, face_north_bottom_top}, 2);
        l2 = {1'b0, lvl, 1'b0};
        l4 = {lvl, 2'b00};

        flags_next.w = face_f(w, c, l2);
        flags_next.e = face_f(e, c, l2);
        flags_next.s = face_f(s, c, l2);
        flags_next.n = face_f(n, c, l2);
        flags_next.b = face_f(b, c, l2);
        flags_next.t = face_f(t, c, l2);

        flags_next.ws  = edge_f(c, pick(edges_xy, 0), w, s, l4);
        flags_next.wn  = edge_f(c, pick(edges_xy, 1), w, n, l4);
        flags_next.es  = edge_f(c, pick(edges_xy, 2), e, s, l4);
        flags_next.en_ = edge_f(c, pick(edges_xy, 3), e, n, l4);
        flags_next.wb  = edge_f(c, pick(edges_xz, 0), w, b, l4);
        flags_next.wt  = edge_f(c, pick(edges_xz, 1), w, t, l4);
        flags_next.eb  = edge_f(c, pick(edges_xz, 2), e, b, l4);
        flags_next.et  = edge_f(c, pick(edges_xz, 3), e, t, l4);
        flags_next.sb  = edge_f(c, pick(edges_yz, 0), s, b, l4);
        flags_next.st  = edge_f(c, pick(edges_yz, 1), s, t, l4);
        flags_next.nb  = edge_f(c, pick(edges_yz, 2), n, b, l4);
        flags_next.nt  = edge_f(c, pick(edges_yz, 3), n, t, l4);

        flags_next.wsb = pick(nodes_low, 0) >= lvl;
        flags_next.esb = pick(nodes_low, 1) >= lvl;
        flags_next.wnb = pick(nodes_low, 2) >= lvl;
        flags_next.enb = pick(nodes_low, 3) >= lvl;
        flags_next.wst = pick(nodes_high, 0) >= lvl;
        flags_next.est = pick(nodes_high, 1) >= lvl;
        flags_next.wnt = pick(nodes_high, 2) >= lvl;
        flags_next.ent = pick(nodes_high, 3) >= lvl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_next;
            inv_x_reg <= inv_dx;
            inv_y_reg <= inv_dy;
            inv_z_reg <= inv_dz;
        end
    end

    assign flags = flags_reg;
    assign inv_x = inv_x_reg;
    assign inv_y = inv_y_reg;
    assign inv_z = inv_z_reg;
endmodule

// File: design/mgad_lane.sv
// One axis lane: gradient magnitude, then the square of |g| * inv; three register stages in all.
// Depends on mgad_pkg.
`timescale 1ns / 1ps
module mgad_lane (
    input  logic                         clk,
    input  logic                         en,
    input  mgad_pkg::lane_flags_t        lf,
    input  logic [mgad_pkg::INV_W-1:0]   inv,
    output logic [mgad_pkg::SQ_W-1:0]    sq
);
    localparam int MW = mgad_pkg::MAG_W;
    localparam int IW = mgad_pkg::INV_W;

    logic [MW-1:0]     pos, neg, mag_next;
    logic [MW-1:0]     mag_reg;
    logic [IW-1:0]     inv_reg;
    logic [2*MW-2:0]   mag_sq_reg;
    logic [2*IW-1:0]   inv_sq_reg;
    logic [mgad_pkg::SQ_W-1:0] sq_reg;

    // Weight faces by 4, edges by 2, nodes by 1 on each side.
    always_comb
    begin
        pos = MW'({lf.face_p, 2'b00}) + MW'($countones(lf.node_p))
            + MW'({$countones(lf.edge_p), 1'b0});
        neg = MW'({lf.face_m, 2'b00}) + MW'($countones(lf.node_m))
            + MW'({$countones(lf.edge_m), 1'b0});
        mag_next = (pos >= neg) ? pos - neg : neg - pos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= mag_next;
            inv_reg    <= inv;
            mag_sq_reg <= (2*MW-1)'(mag_reg) * (2*MW-1)'(mag_reg);
            inv_sq_reg <= (2*IW)'(inv_reg) * (2*IW)'(inv_reg);
            sq_reg     <= mgad_pkg::SQ_W'(inv_sq_reg) * mgad_pkg::SQ_W'(mag_sq_reg);
        end
    end

    assign sq = sq_reg;
endmodule

// File: design/mgad_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on mgad_pkg.
`timescale 1ns / 1ps
module mgad_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [mgad_pkg::RAD_W-1:0]    radicand,
    output logic [mgad_pkg::ROOT_W-1:0]   root
);
    localparam int RW = mgad_pkg::RAD_W;
    localparam int NW = mgad_pkg::ROOT_W;
    localparam int MW = mgad_pkg::REM_W;

    logic [RW-1:0] rad_reg  [NW];
    logic [MW-1:0] rem_reg  [NW];
    logic [NW-1:0] root_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_step
            logic [RW-1:0] rad_in;
            logic [MW-1:0] rem_in;
            logic [NW-1:0] root_in;
            logic [MW+1:0] cur, trial;

            if (k == 0)
            begin : g_first
                assign rad_in  = radicand;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // Bring down two radicand bits, try root*4+1.
            assign cur   = {rem_in, rad_in[RW-1 -: 2]};
            assign trial = (MW+2)'({root_in, 2'b01});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k] <= {rad_in[RW-3:0], 2'b00};
                    if (cur >= trial)
                    begin
                        rem_reg[k]  <= MW'(cur - trial);
                        root_reg[k] <= {root_in[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= MW'(cur);
                        root_reg[k] <= {root_in[NW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[NW-1];
endmodule

// File: design/marker_gradient_area_density.sv
// Stages: 1 threshold, 3 lane, 1 sum, 38 root.
// Throughput: one cell per cycle while the output is not stalled; every stage is registered and advances together.
// The pipeline stalls as a whole only while a finished result waits at the output.
// Reset: valid bits clear, level_reg returns to 16384; data registers are not reset.
// Depends on mgad_pkg, mgad_flags, mgad_lane, mgad_sqrt and the defines header.
`timescale 1ns / 1ps
`include "marker_gradient_area_density_defines.svh"
module marker_gradient_area_density #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] center_value,
    input  logic [47:0] face_west_east_south,
    input  logic [47:0] face_north_bottom_top,
    input  logic [63:0] edges_xy,
    input  logic [63:0] edges_xz,
    input  logic [63:0] edges_yz,
    input  logic [63:0] nodes_low,
    input  logic [63:0] nodes_high,
    input  logic [31:0] inv_dx,
    input  logic [31:0] inv_dy,
    input  logic [31:0] inv_dz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] area_density
);
    localparam int NST = 5 + mgad_pkg::ROOT_W;

    logic [15:0]     level_reg;
    logic [NST-1:0]  vld_reg;
    logic            adv;
    mgad_pkg::cell_flags_t f;
    logic [mgad_pkg::INV_W-1:0] inv_x, inv_y, inv_z;
    mgad_pkg::lane_flags_t lf_x, lf_y, lf_z;
    logic [mgad_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;
    logic [mgad_pkg::SUM_W-1:0] sum_reg;
    logic [mgad_pkg::ROOT_W-1:0] root;

    assign adv      = !vld_reg[NST-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= mgad_pkg::LEVEL_RESET;
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
                level_reg <= cfg_write_data;
            if (adv)
                vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    mgad_flags #(.SAMPLE_BITS(SAMPLE_BITS)) u_flags (
        .clk(clk), .en(adv), .level(level_reg),
        .center_value(center_value),
        .face_west_east_south(face_west_east_south),
        .face_north_bottom_top(face_north_bottom_top),
        .edges_xy(edges_xy), .edges_xz(edges_xz), .edges_yz(edges_yz),
        .nodes_low(nodes_low), .nodes_high(nodes_high),
        .inv_dx(inv_dx), .inv_dy(inv_dy), .inv_dz(inv_dz),
        .flags(f), .inv_x(inv_x), .inv_y(inv_y), .inv_z(inv_z)
    );

    // Route the shared flags to each axis as positive and negative sides.
    always_comb
    begin
        lf_x.face_p = f.e;  lf_x.face_m = f.w;
        lf_x.node_p = {f.ent, f.enb, f.est, f.esb};
        lf_x.node_m = {f.wnt, f.wnb, f.wst, f.wsb};
        lf_x.edge_p = {f.es, f.en_, f.eb, f.et};
        lf_x.edge_m = {f.ws, f.wn, f.wb, f.wt};

        lf_y.face_p = f.n;  lf_y.face_m = f.s;
        lf_y.node_p = {f.ent, f.enb, f.wnt, f.wnb};
        lf_y.node_m = {f.est, f.esb, f.wst, f.wsb};
        lf_y.edge_p = {f.wn, f.en_, f.nb, f.nt};
        lf_y.edge_m = {f.ws, f.es, f.sb, f.st};

        lf_z.face_p = f.t;  lf_z.face_m = f.b;
        lf_z.node_p = {f.est, f.wst, f.ent, f.wnt};
        lf_z.node_m = {f.esb, f.wsb, f.enb, f.wnb};
        lf_z.edge_p = {f.wt, f.et, f.st, f.nt};
        lf_z.edge_m = {f.wb, f.eb, f.sb, f.nb};
    end

    mgad_lane u_lane_x (.clk(clk), .en(adv), .lf(lf_x), .inv(inv_x), .sq(sq_x));
    mgad_lane u_lane_y (.clk(clk), .en(adv), .lf(lf_y), .inv(inv_y), .sq(sq_y));
    mgad_lane u_lane_z (.clk(clk), .en(adv), .lf(lf_z), .inv(inv_z), .sq(sq_z));

    always_ff @(posedge clk)
    begin
        if (adv)
            sum_reg <= mgad_pkg::SUM_W'(sq_x) + mgad_pkg::SUM_W'(sq_y)
                     + mgad_pkg::SUM_W'(sq_z);
    end

    mgad_sqrt u_sqrt (
        .clk(clk), .en(adv),
        .radicand(mgad_pkg::RAD_W'(sum_reg)),
        .root(root)
    );

    // Drop the four extra fraction bits of the Q.20 scale.
    assign area_density = mgad_pkg::OUT_W'(root[mgad_pkg::ROOT_W-1:mgad_pkg::FRAC_DROP]);
    assign out_valid    = vld_reg[NST-1];

    `MGAD_ASSERT(a_empty_accepts, !out_valid |-> in_ready, "input stalled with output empty")
    `MGAD_ASSERT(a_enter_tracked, (in_valid && in_ready) |=> vld_reg[0], "request lost at entry")
    `MGAD_ASSERT_ALWAYS(a_out_range, area_density[39:34] == 6'd0, "area density out of range")
    `MGAD_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> $stable(vld_reg), "pipeline moved while stalled")
endmodule
